// File: hw/rtl/svpwm_pkg.sv
`default_nettype none

package svpwm_pkg;

  // Field widths
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned MI_W     = 16;
  localparam int unsigned SECTOR_W = 3;
  localparam int unsigned ANGLE_W  = 10;
  localparam int unsigned SINE_W   = 16;

  // Parameter defaults
  localparam int unsigned TABLE_DEPTH_DEF = 1024;
  localparam int unsigned SCALE_SHIFT_DEF = 9;
  localparam int unsigned SINE_PEAK_DEF   = 57600;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd7200;

  // pi in unsigned Q2.30
  localparam logic [31:0] PI_Q30 = 32'd3373259426;

  // Sector codes; codes above SECTOR_5 are invalid
  localparam logic [SECTOR_W-1:0] SECTOR_0 = 3'd0;
  localparam logic [SECTOR_W-1:0] SECTOR_1 = 3'd1;
  localparam logic [SECTOR_W-1:0] SECTOR_2 = 3'd2;
  localparam logic [SECTOR_W-1:0] SECTOR_3 = 3'd3;
  localparam logic [SECTOR_W-1:0] SECTOR_4 = 3'd4;
  localparam logic [SECTOR_W-1:0] SECTOR_5 = 3'd5;

  // Sine table fill sequencer
  typedef enum logic [3:0] {
    FS_SQUARE,
    FS_X2,
    FS_MUL,
    FS_DIVLD,
    FS_DIV,
    FS_ACC,
    FS_SCALE,
    FS_WRITE,
    FS_DONE
  } fill_state_t;

endpackage

`default_nettype wire

// File: hw/rtl/svpwm_ram.sv
`default_nettype none

module svpwm_ram #(
  parameter int unsigned WIDTH = svpwm_pkg::SINE_W,
  parameter int unsigned DEPTH = svpwm_pkg::TABLE_DEPTH_DEF,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_a_r <= mem_r[raddr_a];
      rdata_b_r <= mem_r[raddr_b];
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

`default_nettype wire

// File: hw/rtl/svpwm_sine_fill.sv
`default_nettype none

module svpwm_sine_fill #(
  parameter int unsigned TABLE_DEPTH = svpwm_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned SINE_PEAK   = svpwm_pkg::SINE_PEAK_DEF,
  localparam int unsigned AW = $clog2(TABLE_DEPTH)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  output logic                          fill_we,
  output logic [AW-1:0]                 fill_addr,
  output logic [svpwm_pkg::SINE_W-1:0]  fill_data,
  output logic                          fill_done
);

  import svpwm_pkg::*;

  // Angle i*pi/(3*(depth-1)) in Q2.30, stepped as quotient plus remainder
  localparam int unsigned   X_DEN      = 3 * (TABLE_DEPTH - 1);
  localparam int unsigned   RW         = $clog2(X_DEN + 1);
  localparam logic [31:0]   X_STEP     = PI_Q30 / X_DEN;
  localparam logic [RW-1:0] X_REM_STEP = RW'(PI_Q30 % X_DEN);
  localparam logic [RW:0]   X_DEN_V    = (RW+1)'(X_DEN);
  localparam logic [AW-1:0] IDX_LAST   = AW'(TABLE_DEPTH - 1);
  localparam logic [2:0]    K_FIRST    = 3'd1;
  localparam logic [2:0]    K_LAST     = 3'd7;
  localparam logic [4:0]    DIV_LAST   = 5'd31;
  localparam logic [31:0]   PEAK_V     = 32'(SINE_PEAK);

  // Taylor divisor (2k)(2k+1)
  function automatic logic [7:0] term_div(input logic [2:0] k);
    logic [7:0] m;
    m = 8'({k, 1'b0});
    return m * (m + 8'd1);
  endfunction

  fill_state_t state_r, state_nxt;

  logic [AW-1:0] idx_r, idx_nxt;
  logic [31:0]   x_r, x_nxt;
  logic [RW-1:0] xrem_r, xrem_nxt;
  logic [31:0]   x2_r, x2_nxt;
  logic [31:0]   term_r, term_nxt;
  logic [31:0]   sum_r, sum_nxt;
  logic [2:0]    k_r, k_nxt;
  logic [63:0]   mul_r, mul_nxt;
  logic [31:0]   q_r, q_nxt;
  logic [7:0]    drem_r, drem_nxt;
  logic [4:0]    cnt_r, cnt_nxt;

  logic [31:0]   op_a;
  logic [31:0]   op_b;
  logic [63:0]   prod;
  logic [7:0]    divisor;
  logic [8:0]    dshift;
  logic          dge;
  logic [RW:0]   xrem_sum;
  logic          x_carry;

  // Shared multiplier
  always_comb begin
    unique case (state_r)
      FS_SQUARE: begin
        op_a = x_r;
        op_b = x_r;
      end
      FS_MUL: begin
        op_a = term_r;
        op_b = x2_r;
      end
      default: begin
        op_a = sum_r;
        op_b = PEAK_V;
      end
    endcase
  end

  assign prod = 64'(op_a) * 64'(op_b);

  // Restoring divider step, one quotient bit per cycle
  assign divisor = term_div(k_r);
  assign dshift  = {drem_r, q_r[31]};
  assign dge     = dshift >= {1'b0, divisor};

  assign xrem_sum = {1'b0, xrem_r} + {1'b0, X_REM_STEP};
  assign x_carry  = xrem_sum >= X_DEN_V;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FS_SQUARE: state_nxt = FS_X2;
      FS_X2:     state_nxt = FS_MUL;
      FS_MUL:    state_nxt = FS_DIVLD;
      FS_DIVLD:  state_nxt = FS_DIV;
      FS_DIV: begin
        if (cnt_r == DIV_LAST) begin
          state_nxt = FS_ACC;
        end
      end
      FS_ACC:    state_nxt = (k_r == K_LAST) ? FS_SCALE : FS_MUL;
      FS_SCALE:  state_nxt = FS_WRITE;
      FS_WRITE:  state_nxt = (idx_r == IDX_LAST) ? FS_DONE : FS_SQUARE;
      FS_DONE:   state_nxt = FS_DONE;
      default:   state_nxt = FS_DONE;
    endcase
  end

  always_comb begin
    idx_nxt  = idx_r;
    x_nxt    = x_r;
    xrem_nxt = xrem_r;
    x2_nxt   = x2_r;
    term_nxt = term_r;
    sum_nxt  = sum_r;
    k_nxt    = k_r;
    mul_nxt  = mul_r;
    q_nxt    = q_r;
    drem_nxt = drem_r;
    cnt_nxt  = cnt_r;
    fill_we  = 1'b0;
    unique case (state_r)
      FS_SQUARE: mul_nxt = prod;
      FS_X2: begin
        x2_nxt   = mul_r[61:30];
        term_nxt = x_r;
        sum_nxt  = x_r;
        k_nxt    = K_FIRST;
      end
      FS_MUL: mul_nxt = prod;
      FS_DIVLD: begin
        q_nxt    = mul_r[61:30];
        drem_nxt = '0;
        cnt_nxt  = '0;
      end
      FS_DIV: begin
        q_nxt    = {q_r[30:0], dge};
        drem_nxt = dge ? 8'(dshift - {1'b0, divisor}) : dshift[7:0];
        cnt_nxt  = cnt_r + 5'd1;
      end
      FS_ACC: begin
        // odd terms subtract, even terms add
        term_nxt = q_r;
        sum_nxt  = k_r[0] ? (sum_r - q_r) : (sum_r + q_r);
        k_nxt    = k_r + 3'd1;
      end
      FS_SCALE: mul_nxt = prod;
      FS_WRITE: begin
        fill_we = 1'b1;
        if (idx_r != IDX_LAST) begin
          idx_nxt  = idx_r + AW'(1);
          x_nxt    = x_r + X_STEP + 32'(x_carry);
          xrem_nxt = x_carry ? RW'(xrem_sum - X_DEN_V) : xrem_sum[RW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FS_SQUARE;
      idx_r   <= '0;
      x_r     <= '0;
      xrem_r  <= '0;
      k_r     <= K_FIRST;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      x_r     <= x_nxt;
      xrem_r  <= xrem_nxt;
      k_r     <= k_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x2_r   <= x2_nxt;
    term_r <= term_nxt;
    sum_r  <= sum_nxt;
    mul_r  <= mul_nxt;
    q_r    <= q_nxt;
    drem_r <= drem_nxt;
  end

  assign fill_addr = idx_r;
  assign fill_data = mul_r[30 +: SINE_W];
  assign fill_done = state_r == FS_DONE;

`ifndef SYNTH
  a_no_write_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    fill_we |-> !fill_done)
    else $error("table write after fill finished");

  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    fill_done |=> fill_done)
    else $error("fill done dropped without reset");

  a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(fill_done) |-> $past(fill_we) && $past(fill_addr) == IDX_LAST)
    else $error("fill finished before last entry was written");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/svpwm_pipe.sv
`default_nettype none

module svpwm_pipe #(
  parameter int unsigned TABLE_DEPTH = svpwm_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned SCALE_SHIFT = svpwm_pkg::SCALE_SHIFT_DEF,
  localparam int unsigned AW = $clog2(TABLE_DEPTH)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            run,
  input  logic [svpwm_pkg::PERIOD_W-1:0]  pwm_period,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [svpwm_pkg::MI_W-1:0]      in_mod_index,
  input  logic [svpwm_pkg::SECTOR_W-1:0]  in_sector,
  input  logic [svpwm_pkg::ANGLE_W-1:0]   in_sector_angle,
  output logic                            rom_re,
  output logic [AW-1:0]                   rom_addr_a,
  output logic [AW-1:0]                   rom_addr_b,
  input  logic [svpwm_pkg::SINE_W-1:0]    rom_data_a,
  input  logic [svpwm_pkg::SINE_W-1:0]    rom_data_b,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [svpwm_pkg::PERIOD_W-1:0]  out_cmp_phase_a,
  output logic [svpwm_pkg::PERIOD_W-1:0]  out_cmp_phase_b,
  output logic [svpwm_pkg::PERIOD_W-1:0]  out_cmp_phase_c,
  output logic                            out_overmodulated,
  output logic                            out_bad_sector
);

  import svpwm_pkg::*;

  localparam int unsigned   CW         = (AW > ANGLE_W) ? AW : ANGLE_W;
  localparam int unsigned   PROD_W     = MI_W + SINE_W;
  localparam logic [CW-1:0] ANGLE_LAST = CW'(TABLE_DEPTH - 1);
  localparam logic [AW-1:0] ADDR_LAST  = AW'(TABLE_DEPTH - 1);

  // Valid bits and per-stage ready
  logic v1_r, v2_r, v3_r, out_valid_r;
  logic rdy1, rdy2, rdy3, rdy_o;
  logic in_acc;

  // Stage 1: table read
  logic [MI_W-1:0]     mi1_r;
  logic [SECTOR_W-1:0] sec1_r;
  logic [CW-1:0]       angle_ext;
  logic [CW-1:0]       angle_sat;

  // Stage 2: active times
  logic [PROD_W-1:0]   prod_ccw;
  logic [PROD_W-1:0]   prod_cw;
  logic [PROD_W-1:0]   tccw2_r, tccw2_nxt;
  logic [PROD_W-1:0]   tcw2_r, tcw2_nxt;
  logic [SECTOR_W-1:0] sec2_r;

  // Stage 3: zero time
  logic [PROD_W:0]     tsum;
  logic                ovm3_r, ovm3_nxt;
  logic [PERIOD_W-1:0] tz3_r, tz3_nxt;
  logic [PERIOD_W-1:0] cw3_r, cw3_nxt;
  logic [PERIOD_W-1:0] ccw3_r, ccw3_nxt;
  logic [SECTOR_W-1:0] sec3_r;

  // Output stage: sector mux
  logic [PERIOD_W:0]   cw_sum;
  logic [PERIOD_W:0]   ccw_sum;
  logic [PERIOD_W-1:0] c_cw;
  logic [PERIOD_W-1:0] c_ccw;
  logic [PERIOD_W-1:0] hi;
  logic                bad_nxt;
  logic [PERIOD_W-1:0] cmp_a_r, cmp_a_nxt;
  logic [PERIOD_W-1:0] cmp_b_r, cmp_b_nxt;
  logic [PERIOD_W-1:0] cmp_c_r, cmp_c_nxt;
  logic                ovm_r, ovm_nxt;
  logic                bad_r;

  assign rdy_o = !out_valid_r || out_ready;
  assign rdy3  = !v3_r || rdy_o;
  assign rdy2  = !v2_r || rdy3;
  assign rdy1  = !v1_r || rdy2;

  assign in_ready = run && rdy1;
  assign in_acc   = in_valid && in_ready;

  // Saturate the angle, read both the angle and its mirror
  assign angle_ext  = CW'(in_sector_angle);
  assign angle_sat  = (angle_ext > ANGLE_LAST) ? ANGLE_LAST : angle_ext;
  assign rom_addr_a = angle_sat[AW-1:0];
  assign rom_addr_b = ADDR_LAST - angle_sat[AW-1:0];
  assign rom_re     = in_acc;

  // sin(phi) gives t_ccw, sin(60 - phi) gives t_cw
  assign prod_ccw  = PROD_W'(mi1_r) * PROD_W'(rom_data_a);
  assign prod_cw   = PROD_W'(mi1_r) * PROD_W'(rom_data_b);
  assign tccw2_nxt = prod_ccw >> SCALE_SHIFT;
  assign tcw2_nxt  = prod_cw >> SCALE_SHIFT;

  assign tsum     = (PROD_W+1)'(tccw2_r) + (PROD_W+1)'(tcw2_r);
  assign ovm3_nxt = tsum > (PROD_W+1)'(pwm_period);
  assign tz3_nxt  = ovm3_nxt ? '0 : ((pwm_period - tsum[PERIOD_W-1:0]) >> 1);
  assign cw3_nxt  = (tcw2_r > PROD_W'(pwm_period)) ? pwm_period : tcw2_r[PERIOD_W-1:0];
  assign ccw3_nxt = (tccw2_r > PROD_W'(pwm_period)) ? pwm_period : tccw2_r[PERIOD_W-1:0];

  assign cw_sum  = {1'b0, tz3_r} + {1'b0, cw3_r};
  assign ccw_sum = {1'b0, tz3_r} + {1'b0, ccw3_r};
  assign c_cw    = (cw_sum > {1'b0, pwm_period}) ? pwm_period : cw_sum[PERIOD_W-1:0];
  assign c_ccw   = (ccw_sum > {1'b0, pwm_period}) ? pwm_period : ccw_sum[PERIOD_W-1:0];
  assign hi      = pwm_period - tz3_r;
  assign bad_nxt = sec3_r > SECTOR_5;
  assign ovm_nxt = ovm3_r && !bad_nxt;

  always_comb begin
    unique case (sec3_r)
      SECTOR_0: begin
        cmp_a_nxt = tz3_r;
        cmp_b_nxt = c_cw;
        cmp_c_nxt = hi;
      end
      SECTOR_1: begin
        cmp_a_nxt = c_ccw;
        cmp_b_nxt = tz3_r;
        cmp_c_nxt = hi;
      end
      SECTOR_2: begin
        cmp_a_nxt = hi;
        cmp_b_nxt = tz3_r;
        cmp_c_nxt = c_cw;
      end
      SECTOR_3: begin
        cmp_a_nxt = hi;
        cmp_b_nxt = c_ccw;
        cmp_c_nxt = tz3_r;
      end
      SECTOR_4: begin
        cmp_a_nxt = c_cw;
        cmp_b_nxt = hi;
        cmp_c_nxt = tz3_r;
      end
      SECTOR_5: begin
        cmp_a_nxt = tz3_r;
        cmp_b_nxt = hi;
        cmp_c_nxt = c_ccw;
      end
      default: begin
        cmp_a_nxt = '0;
        cmp_b_nxt = '0;
        cmp_c_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_acc;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
      if (rdy_o) begin
        out_valid_r <= v3_r;
      end
    end
  end

  // Payload: load on advance, hold otherwise
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mi1_r  <= in_mod_index;
      sec1_r <= in_sector;
    end
    if (rdy2 && v1_r) begin
      tccw2_r <= tccw2_nxt;
      tcw2_r  <= tcw2_nxt;
      sec2_r  <= sec1_r;
    end
    if (rdy3 && v2_r) begin
      ovm3_r <= ovm3_nxt;
      tz3_r  <= tz3_nxt;
      cw3_r  <= cw3_nxt;
      ccw3_r <= ccw3_nxt;
      sec3_r <= sec2_r;
    end
    if (rdy_o && v3_r) begin
      cmp_a_r <= cmp_a_nxt;
      cmp_b_r <= cmp_b_nxt;
      cmp_c_r <= cmp_c_nxt;
      ovm_r   <= ovm_nxt;
      bad_r   <= bad_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_cmp_phase_a   = cmp_a_r;
  assign out_cmp_phase_b   = cmp_b_r;
  assign out_cmp_phase_c   = cmp_c_r;
  assign out_overmodulated = ovm_r;
  assign out_bad_sector    = bad_r;

`ifndef SYNTH
  a_bad_sector_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_sector |->
      out_cmp_phase_a == '0 && out_cmp_phase_b == '0 && out_cmp_phase_c == '0 &&
      !out_overmodulated)
    else $error("bad sector word carries nonzero compares");

  a_compare_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_bad_sector |->
      out_cmp_phase_a <= pwm_period && out_cmp_phase_b <= pwm_period &&
      out_cmp_phase_c <= pwm_period)
    else $error("compare above period");

  a_overmod_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overmodulated |->
      (out_cmp_phase_a == '0 || out_cmp_phase_b == '0 || out_cmp_phase_c == '0) &&
      (out_cmp_phase_a == pwm_period || out_cmp_phase_b == pwm_period ||
       out_cmp_phase_c == pwm_period))
    else $error("overmodulated word lacks zero or full compare");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/svpwm_compare_generator.sv
// Space-vector PWM compare generator.
// Input channel (in_valid/in_ready): one word per request with the modulation
// index, the sector (0..5; 6 and 7 are flagged as bad) and the angle within
// the sector. Result channel (out_valid/out_ready): the three phase compare
// values, the overmodulation flag and the bad-sector flag, one word per request.
// Configuration channel (cfg_valid/cfg_ready): writes the PWM period; it is
// always ready and should only be written while no request is in flight.
// Throughput is one word per cycle while out_ready stays high. An accepted
// word passes the table read, multiply, zero-time subtract and sector mux
// stages, each ending in a register; the last is the output register.
// After reset the sine table is computed into on-chip RAM by a serial Taylor
// series unit (one serial divide per series term), and in_ready stays low
// until every entry is written; the period register resets to 7200 and takes
// writes during the fill.
// When the receiver stalls, each stage holds its word; empty stages still
// fill, and in_ready falls only once all four stages hold a word.

`default_nettype none

module svpwm_compare_generator #(
  parameter int unsigned TABLE_DEPTH = svpwm_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned SCALE_SHIFT = svpwm_pkg::SCALE_SHIFT_DEF,
  parameter int unsigned SINE_PEAK   = svpwm_pkg::SINE_PEAK_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [svpwm_pkg::PERIOD_W-1:0]  cfg_pwm_period,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [svpwm_pkg::MI_W-1:0]      in_mod_index,
  input  logic [svpwm_pkg::SECTOR_W-1:0]  in_sector,
  input  logic [svpwm_pkg::ANGLE_W-1:0]   in_sector_angle,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [svpwm_pkg::PERIOD_W-1:0]  out_cmp_phase_a,
  output logic [svpwm_pkg::PERIOD_W-1:0]  out_cmp_phase_b,
  output logic [svpwm_pkg::PERIOD_W-1:0]  out_cmp_phase_c,
  output logic                            out_overmodulated,
  output logic                            out_bad_sector
);

  import svpwm_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  logic [PERIOD_W-1:0] pwm_period_r;

  // Table write side (fill sequencer)
  logic                fill_we;
  logic [AW-1:0]       fill_addr;
  logic [SINE_W-1:0]   fill_data;
  logic                fill_done;

  // Table read side (pipeline)
  logic                rom_re;
  logic [AW-1:0]       rom_addr_a;
  logic [AW-1:0]       rom_addr_b;
  logic [SINE_W-1:0]   rom_data_a;
  logic [SINE_W-1:0]   rom_data_b;

  // Period register: take every write, hold otherwise
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pwm_period_r <= PERIOD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      pwm_period_r <= cfg_pwm_period;
    end
  end

  // Build the sine table after reset
  svpwm_sine_fill #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .SINE_PEAK   (SINE_PEAK)
  ) u_fill (
    .clk       (clk),
    .rst_n     (rst_n),
    .fill_we   (fill_we),
    .fill_addr (fill_addr),
    .fill_data (fill_data),
    .fill_done (fill_done)
  );

  // Sine table: one write port for the fill, two read ports for angle and mirror
  svpwm_ram #(
    .WIDTH (SINE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_sine_ram (
    .clk     (clk),
    .we      (fill_we),
    .waddr   (fill_addr),
    .wdata   (fill_data),
    .re      (rom_re),
    .raddr_a (rom_addr_a),
    .raddr_b (rom_addr_b),
    .rdata_a (rom_data_a),
    .rdata_b (rom_data_b)
  );

  // Compare pipeline; no words enter until the table is complete
  svpwm_pipe #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .SCALE_SHIFT (SCALE_SHIFT)
  ) u_pipe (
    .clk               (clk),
    .rst_n             (rst_n),
    .run               (fill_done),
    .pwm_period        (pwm_period_r),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_mod_index      (in_mod_index),
    .in_sector         (in_sector),
    .in_sector_angle   (in_sector_angle),
    .rom_re            (rom_re),
    .rom_addr_a        (rom_addr_a),
    .rom_addr_b        (rom_addr_b),
    .rom_data_a        (rom_data_a),
    .rom_data_b        (rom_data_b),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_cmp_phase_a   (out_cmp_phase_a),
    .out_cmp_phase_b   (out_cmp_phase_b),
    .out_cmp_phase_c   (out_cmp_phase_c),
    .out_overmodulated (out_overmodulated),
    .out_bad_sector    (out_bad_sector)
  );

endmodule

`default_nettype wire

// File: tb/svpwm_compare_checker.sv
module svpwm_compare_checker #(
  parameter int unsigned TABLE_DEPTH = svpwm_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned SCALE_SHIFT = svpwm_pkg::SCALE_SHIFT_DEF,
  parameter int unsigned SINE_PEAK   = svpwm_pkg::SINE_PEAK_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [svpwm_pkg::PERIOD_W-1:0]  cfg_pwm_period,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [svpwm_pkg::MI_W-1:0]      in_mod_index,
  input  logic [svpwm_pkg::SECTOR_W-1:0]  in_sector,
  input  logic [svpwm_pkg::ANGLE_W-1:0]   in_sector_angle,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [svpwm_pkg::PERIOD_W-1:0]  out_cmp_phase_a,
  input  logic [svpwm_pkg::PERIOD_W-1:0]  out_cmp_phase_b,
  input  logic [svpwm_pkg::PERIOD_W-1:0]  out_cmp_phase_c,
  input  logic                            out_overmodulated,
  input  logic                            out_bad_sector,
  output int unsigned                     fail_count,
  output int unsigned                     pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  import svpwm_pkg::*;

  typedef struct packed {
    logic [PERIOD_W-1:0] cmp_a;
    logic [PERIOD_W-1:0] cmp_b;
    logic [PERIOD_W-1:0] cmp_c;
    logic                ovm;
    logic                bad;
  } compare_word_t;

  typedef struct packed {
    logic [MI_W-1:0]     mi;
    logic [SECTOR_W-1:0] sec;
    logic [ANGLE_W-1:0]  ang;
    compare_word_t       cmp;
  } compare_request_t;

  logic [SINE_W-1:0]   sine_lut [TABLE_DEPTH];
  logic [PERIOD_W-1:0] period_copy;
  compare_request_t    compare_fifo [$];
  int unsigned         failures;

  initial begin
    fail_count    = 0;
    pending_count = 0;
    failures      = 0;
    period_copy   = PERIOD_RESET;
  end

  // Q2.30 Taylor series through x^15, scaled to the table peak
  function automatic logic [SINE_W-1:0] sine_entry(int unsigned idx);
    longint unsigned x, x2, term, sum, k, v;
    x    = (64'(idx) * 64'(PI_Q30)) / (64'd3 * 64'(TABLE_DEPTH - 1));
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    for (k = 1; k <= 7; k++) begin
      term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
      if (k[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    v = (64'(SINE_PEAK) * sum) >> 30;
    return v[SINE_W-1:0];
  endfunction

  initial begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      sine_lut[i] = sine_entry(i);
    end
  end

  function automatic longint unsigned clamp_top(longint unsigned v, longint unsigned top);
    return (v > top) ? top : v;
  endfunction

  function automatic compare_word_t predict_compares(logic [MI_W-1:0] mi,
                                                    logic [SECTOR_W-1:0] sec,
                                                    logic [ANGLE_W-1:0] ang,
                                                    logic [PERIOD_W-1:0] period);
    longint unsigned p, m, idx, t_cw, t_ccw, t_z, hi, c_cw, c_ccw, va, vb, vc;
    compare_word_t w;
    w = '0;
    if (sec > SECTOR_5) begin
      w.bad = 1'b1;
      return w;
    end
    p   = period;
    m   = mi;
    idx = ang;
    if (idx > TABLE_DEPTH - 1) begin
      idx = TABLE_DEPTH - 1;
    end
    t_ccw = (m * 64'(sine_lut[idx])) >> SCALE_SHIFT;
    t_cw  = (m * 64'(sine_lut[TABLE_DEPTH - 1 - idx])) >> SCALE_SHIFT;
    if (t_cw + t_ccw > p) begin
      t_z   = 0;
      w.ovm = 1'b1;
    end else begin
      t_z = (p - t_cw - t_ccw) >> 1;
    end
    hi    = p - t_z;
    c_cw  = clamp_top(t_z + t_cw, p);
    c_ccw = clamp_top(t_z + t_ccw, p);
    case (sec)
      SECTOR_0: begin va = t_z;   vb = c_cw;  vc = hi;    end
      SECTOR_1: begin va = c_ccw; vb = t_z;   vc = hi;    end
      SECTOR_2: begin va = hi;    vb = t_z;   vc = c_cw;  end
      SECTOR_3: begin va = hi;    vb = c_ccw; vc = t_z;   end
      SECTOR_4: begin va = c_cw;  vb = hi;    vc = t_z;   end
      default: begin  va = t_z;   vb = hi;    vc = c_ccw; end
    endcase
    w.cmp_a = clamp_top(va, p);
    w.cmp_b = clamp_top(vb, p);
    w.cmp_c = clamp_top(vc, p);
    return w;
  endfunction

  always @(posedge clk) begin
    compare_request_t req;
    compare_word_t    got;
    if (!rst_n) begin
      period_copy = PERIOD_RESET;
      compare_fifo.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        period_copy = cfg_pwm_period;
      end
      if (in_valid && in_ready) begin
        req.mi  = in_mod_index;
        req.sec = in_sector;
        req.ang = in_sector_angle;
        req.cmp = predict_compares(in_mod_index, in_sector, in_sector_angle, period_copy);
        compare_fifo.push_back(req);
      end
      if (out_valid && out_ready) begin
        got.cmp_a = out_cmp_phase_a;
        got.cmp_b = out_cmp_phase_b;
        got.cmp_c = out_cmp_phase_c;
        got.ovm   = out_overmodulated;
        got.bad   = out_bad_sector;
        if (compare_fifo.size() == 0) begin
          failures++;
          if (failures <= 10) begin
            $display("%t: result word with nothing outstanding: a=%0d b=%0d c=%0d ovm=%0b bad=%0b",
                     $realtime, got.cmp_a, got.cmp_b, got.cmp_c, got.ovm, got.bad);
          end
        end else begin
          req = compare_fifo.pop_front();
          if (got.cmp_a !== req.cmp.cmp_a || got.cmp_b !== req.cmp.cmp_b ||
              got.cmp_c !== req.cmp.cmp_c || got.ovm !== req.cmp.ovm ||
              got.bad !== req.cmp.bad) begin
            failures++;
            if (failures <= 10) begin
              $display("%t: mi=%0d sector=%0d angle=%0d period=%0d", $realtime,
                       req.mi, req.sec, req.ang, period_copy);
              $display("  expected a=%0d b=%0d c=%0d ovm=%0b bad=%0b",
                       req.cmp.cmp_a, req.cmp.cmp_b, req.cmp.cmp_c, req.cmp.ovm, req.cmp.bad);
              $display("  actual   a=%0d b=%0d c=%0d ovm=%0b bad=%0b",
                       got.cmp_a, got.cmp_b, got.cmp_c, got.ovm, got.bad);
            end
          end
        end
      end
    end
    fail_count    <= failures;
    pending_count <= compare_fifo.size();
  end

endmodule

// File: tb/svpwm_compare_generator_tb.sv
module svpwm_compare_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import svpwm_pkg::*;

  // Cycles with no word moving on any channel before the run is abandoned.
  // The sine table fill after reset keeps in_ready low; the limit must outlast it.
  localparam int unsigned STALL_LIMIT = 800_000;
  // Length of the one deliberate receiver hold-off, long enough to back up
  // all four pipeline stages and push in_ready low.
  localparam int unsigned LONG_HOLD   = 40;
  // Settle time after the last result.
  localparam int unsigned SETTLE      = 8;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  logic                 clk;
  logic                 rst_n           = 1'b0;
  logic                 cfg_valid       = 1'b0;
  logic                 cfg_ready;
  logic [PERIOD_W-1:0]  cfg_pwm_period  = '0;
  logic                 in_valid        = 1'b0;
  logic                 in_ready;
  logic [MI_W-1:0]      in_mod_index    = '0;
  logic [SECTOR_W-1:0]  in_sector       = '0;
  logic [ANGLE_W-1:0]   in_sector_angle = '0;
  logic                 out_valid;
  logic                 out_ready       = 1'b0;
  logic [PERIOD_W-1:0]  out_cmp_phase_a;
  logic [PERIOD_W-1:0]  out_cmp_phase_b;
  logic [PERIOD_W-1:0]  out_cmp_phase_c;
  logic                 out_overmodulated;
  logic                 out_bad_sector;

  int unsigned          fail_count;
  int unsigned          pending_count;

  idle_mode_t           idle_mode     = IDLE_NONE;
  logic                 long_hold_req = 1'b0;
  logic [PERIOD_W-1:0]  cur_period    = PERIOD_RESET;

  svpwm_compare_generator uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_pwm_period    (cfg_pwm_period),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_mod_index      (in_mod_index),
    .in_sector         (in_sector),
    .in_sector_angle   (in_sector_angle),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_cmp_phase_a   (out_cmp_phase_a),
    .out_cmp_phase_b   (out_cmp_phase_b),
    .out_cmp_phase_c   (out_cmp_phase_c),
    .out_overmodulated (out_overmodulated),
    .out_bad_sector    (out_bad_sector)
  );

  svpwm_compare_checker compare_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_pwm_period    (cfg_pwm_period),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_mod_index      (in_mod_index),
    .in_sector         (in_sector),
    .in_sector_angle   (in_sector_angle),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_cmp_phase_a   (out_cmp_phase_a),
    .out_cmp_phase_b   (out_cmp_phase_b),
    .out_cmp_phase_c   (out_cmp_phase_c),
    .out_overmodulated (out_overmodulated),
    .out_bad_sector    (out_bad_sector),
    .fail_count        (fail_count),
    .pending_count     (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result sink: drop out_ready at random per the current idle mode. One
  // long hold-off, counted here, runs when the stimulus asks for it.
  initial begin : result_sink
    int unsigned hold_left;
    bit          hold_done;
    int unsigned pct;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (idle_mode)
          IDLE_RECV: pct = 46;
          IDLE_BOTH: pct = 7;
          default:   pct = 0;
        endcase
        out_ready <= ($urandom_range(0, 99) >= pct);
      end
    end
  end

  // Watchdog: count cycles in which no word moves on any channel.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Write the PWM period; hold cfg_valid until the word is taken.
  task automatic write_period(logic [PERIOD_W-1:0] value);
    cfg_valid      <= 1'b1;
    cfg_pwm_period <= value;
    cur_period     <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Offer one request word, maybe after a short sender gap, and hold it until
  // accepted. in_valid stays high into the next word when there is no gap.
  task automatic push_request(logic [MI_W-1:0] mi, logic [SECTOR_W-1:0] sec,
                              logic [ANGLE_W-1:0] ang);
    int unsigned pct;
    case (idle_mode)
      IDLE_SEND: pct = 46;
      IDLE_BOTH: pct = 7;
      default:   pct = 0;
    endcase
    if ($urandom_range(0, 99) < pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_mod_index    <= mi;
    in_sector       <= sec;
    in_sector_angle <= ang;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop sending and wait until every outstanding result has come back.
  // The first edge lets the checker count the word just accepted.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Random request: mostly modulation indexes around the overmodulation
  // boundary for the current period, some full range, a few extremes.
  task automatic random_request();
    int unsigned mi_cap;
    int unsigned pick;
    logic [MI_W-1:0]     mi;
    logic [ANGLE_W-1:0]  ang;
    mi_cap = cur_period / 90 + 2;
    pick   = $urandom_range(0, 99);
    if (pick < 60) begin
      mi = $urandom_range(0, mi_cap);
    end else if (pick < 80) begin
      mi = $urandom_range(0, 16'hFFFF);
    end else if (pick < 92) begin
      mi = $urandom_range(mi_cap / 2, mi_cap * 2);
    end else begin
      mi = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    end
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      ang = '0;
    end else if (pick == 1) begin
      ang = '1;
    end else begin
      ang = $urandom_range(0, 1023);
    end
    push_request(mi, $urandom_range(0, 7), ang);
  endtask

  task automatic run_phase(logic [PERIOD_W-1:0] period, idle_mode_t mode, int unsigned count);
    drain_results();
    write_period(period);
    idle_mode <= mode;
    repeat (count) random_request();
  endtask

  initial begin : stimulus
    idle_mode_t mode;
    logic [PERIOD_W-1:0] period;

    // Hold reset low, then release.
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Program the period during the table fill; requests wait on in_ready.
    write_period(PERIOD_RESET);

    // Directed words at period 7200: field extremes, every sector, both
    // invalid sectors, angle ends, and the overmodulation boundary.
    push_request(16'd0,     SECTOR_0, 10'd0);
    push_request(16'hFFFF,  SECTOR_5, 10'd1023);
    push_request(16'hFFFF,  SECTOR_0, 10'd0);
    push_request(16'd40,    SECTOR_0, 10'd300);
    push_request(16'd40,    SECTOR_1, 10'd300);
    push_request(16'd40,    SECTOR_2, 10'd300);
    push_request(16'd40,    SECTOR_3, 10'd300);
    push_request(16'd40,    SECTOR_4, 10'd300);
    push_request(16'd40,    SECTOR_5, 10'd300);
    push_request(16'hFFFF,  3'd6,     10'd1023);
    push_request(16'd50,    3'd7,     10'd512);
    push_request(16'd60,    SECTOR_1, 10'd0);
    push_request(16'd60,    SECTOR_3, 10'd1023);
    push_request(16'd1,     SECTOR_4, 10'd1);
    // Walk the modulation index above the point where the zero time
    // saturates, in sector 2 near mid-angle.
    for (int unsigned m = 68; m <= 78; m += 2) begin
      push_request(m[MI_W-1:0], SECTOR_2, 10'd511);
    end
    push_request(16'd300,   SECTOR_4, 10'd700);
    push_request(16'd300,   SECTOR_5, 10'd100);

    // Extremes of the period: largest, smallest, and zero.
    run_phase(16'hFFFF, IDLE_NONE, 150);
    run_phase(16'd1,    IDLE_SEND, 100);
    run_phase(16'd0,    IDLE_RECV, 60);

    // Long receiver hold-off while words keep coming: fill the pipeline and
    // stall the input.
    drain_results();
    write_period(PERIOD_RESET);
    idle_mode     <= IDLE_NONE;
    long_hold_req <= 1'b1;
    repeat (60) random_request();

    // Random periods, cycling through the idle modes.
    for (int unsigned ph = 0; ph < 8; ph++) begin
      mode   = idle_mode_t'(ph % 4);
      period = (ph % 3 == 0) ? 16'($urandom_range(1, 400)) : 16'($urandom_range(1, 65535));
      run_phase(period, mode, 110);
    end

    drain_results();
    if (fail_count == 0 && pending_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/svpwm_pkg.sv
hw/rtl/svpwm_ram.sv
hw/rtl/svpwm_sine_fill.sv
hw/rtl/svpwm_pipe.sv
hw/rtl/svpwm_compare_generator.sv
tb/svpwm_compare_checker.sv
tb/svpwm_compare_generator_tb.sv
